// File: rtl/gnf_pkg.sv
// ----------------------------------------------------------------------------
// gnf_pkg: shared types and constants for the grid nearest fill block
// Grid geometry, field widths, opcodes, result kinds, register indexes and the
// control structs that pass between the sequencer and the neighbor walker.
// ----------------------------------------------------------------------------
package gnf_pkg;

   localparam int ROW_BITS   = 6;
   localparam int COL_BITS   = 6;
   localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
   localparam int CELL_COUNT = 1 << ADDR_BITS;
   localparam int DIM_BITS   = ROW_BITS + 1;
   localparam int COUNT_BITS = ADDR_BITS + 1;
   localparam int VALUE_BITS = 32;
   localparam int CSR_BITS   = 2;
   localparam int MAX_ROWS   = 1 << ROW_BITS;
   localparam int MAX_COLS   = 1 << COL_BITS;

   typedef logic [ROW_BITS-1:0]   row_type;
   typedef logic [COL_BITS-1:0]   col_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [DIM_BITS-1:0]   dim_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [1:0]            offset_type;

   // Request opcodes.
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Result kinds.
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_FILL = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_BITS-1:0] CSR_NODATA = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_ROWS   = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_COLS   = 2'd2;

   // Reset values of the configuration registers.
   localparam value_type NODATA_RESET = value_type'(-9999);
   localparam dim_type   ROWS_RESET   = dim_type'(MAX_ROWS);
   localparam dim_type   COLS_RESET   = dim_type'(MAX_COLS);

   // Neighbor offsets are coded 0..2 for -1..+1.
   localparam offset_type OFS_MID  = 2'd1;
   localparam offset_type OFS_LAST = 2'd2;

   typedef struct packed {
      logic clear;
      logic step;
   } nbr_ctl_type;

   typedef struct packed {
      addr_type addr;
      logic     inb;
      logic     last;
   } nbr_type;

endpackage

// File: rtl/grid_nearest_fill.sv
// ----------------------------------------------------------------------------
// grid_nearest_fill: nearest-value flood fill over a 64 x 64 grid of words
// Loads and reads grid cells and fills no-data cells breadth first from their
// valued 8-connected neighbors, in place, with one grid memory and one queue.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge where start is high and busy is low.
// Opcode write stores req_cell_value into the addressed cell; it is done at
// the accepting edge, gives no result and never raises busy. Opcode read
// raises busy for one cycle, in state S_READ, and afterwards pulses
// rsp_valid from the result registers with rsp_kind low and the cell word
// (the no-data word for a cell outside the rows and columns in use). Opcode
// run first scans the grid in row-major order and queues every valued cell
// that touches a no-data cell, then pops the queue and hands each popped
// cell's word to its no-data neighbors, which are queued in turn. The scan
// leaves a cell at a no-data center or at its first no-data neighbor; scan
// and fill are paced by the grid memory's single read port, which serves
// one neighbor per cycle. When the queue drains, rsp_valid pulses with
// rsp_kind high and the number of cells filled. Opcode 3 is ignored.
// Results are strobed for exactly one cycle and cannot be held off.
// Configuration is written through csr_write_enable, csr_index and
// csr_write_data while no request is in flight. Reset clears the control
// state and restores the registers; grid and queue contents are kept as-is.
// ----------------------------------------------------------------------------
module grid_nearest_fill (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_opcode,
   input  gnf_pkg::row_type                    req_row,
   input  gnf_pkg::col_type                    req_col,
   input  logic signed [gnf_pkg::VALUE_BITS-1:0] req_cell_value,
   output logic                                rsp_valid,
   output logic                                rsp_kind,
   output logic signed [gnf_pkg::VALUE_BITS-1:0] rsp_read_value,
   output gnf_pkg::count_type                  rsp_cells_filled,
   input  logic                                csr_write_enable,
   input  logic [gnf_pkg::CSR_BITS-1:0]        csr_index,
   input  logic [gnf_pkg::VALUE_BITS-1:0]      csr_write_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_SEED_CTR,
      S_SEED_NB,
      S_SEED_DRAIN,
      S_POP,
      S_POP_WAIT,
      S_BFS_NB,
      S_BFS_DRAIN
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   gnf_pkg::value_type nodata_ff;
   gnf_pkg::dim_type   rows_ff;
   gnf_pkg::dim_type   cols_ff;
   gnf_pkg::dim_type   n_rows, n_cols;

   // Walk state.
   gnf_pkg::row_type   cur_row_ff, cur_row_in;
   gnf_pkg::col_type   cur_col_ff, cur_col_in;
   gnf_pkg::value_type ctr_val_ff, ctr_val_in;
   logic               first_ff, first_in;
   logic               ev_valid_ff, ev_valid_in;
   gnf_pkg::addr_type  ev_addr_ff, ev_addr_in;
   gnf_pkg::count_type head_ff, head_in;
   gnf_pkg::count_type tail_ff, tail_in;
   gnf_pkg::count_type fill_ff, fill_in;
   logic               rd_inside_ff, rd_inside_in;

   // Result registers.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   gnf_pkg::value_type rsp_value_ff, rsp_value_in;
   gnf_pkg::count_type rsp_count_ff, rsp_count_in;

   // Memory ports.
   logic               g_wr_en;
   gnf_pkg::addr_type  g_wr_addr, g_rd_addr;
   gnf_pkg::value_type g_wr_data, g_rd_data;
   logic               q_wr_en;
   gnf_pkg::addr_type  q_wr_addr, q_wr_data, q_rd_data;

   gnf_pkg::nbr_ctl_type nbr_ctl;
   gnf_pkg::nbr_type     nbr;

   logic               accept, req_inside, rd_is_nodata, queue_room;
   gnf_pkg::dim_type   col_next, row_next;

   // Dimension registers above the maximum saturate to it.
   assign n_rows = (rows_ff > gnf_pkg::dim_type'(gnf_pkg::MAX_ROWS)) ?
                   gnf_pkg::dim_type'(gnf_pkg::MAX_ROWS) : rows_ff;
   assign n_cols = (cols_ff > gnf_pkg::dim_type'(gnf_pkg::MAX_COLS)) ?
                   gnf_pkg::dim_type'(gnf_pkg::MAX_COLS) : cols_ff;

   assign accept       = start && (state_ff == S_IDLE);
   assign req_inside   = ({1'b0, req_row} < n_rows) && ({1'b0, req_col} < n_cols);
   assign rd_is_nodata = (g_rd_data == nodata_ff);
   assign queue_room   = tail_ff < gnf_pkg::count_type'(gnf_pkg::CELL_COUNT);
   assign col_next     = {1'b0, cur_col_ff} + gnf_pkg::dim_type'(1);
   assign row_next     = {1'b0, cur_row_ff} + gnf_pkg::dim_type'(1);

   gnf_ram #(
      .DEPTH (gnf_pkg::CELL_COUNT),
      .WIDTH (gnf_pkg::VALUE_BITS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (g_wr_en),
      .wr_addr (g_wr_addr),
      .wr_data (g_wr_data),
      .rd_addr (g_rd_addr),
      .rd_data (g_rd_data)
   );

   // The queue is read at the head every cycle; a pop just moves the head.
   gnf_ram #(
      .DEPTH (gnf_pkg::CELL_COUNT),
      .WIDTH (gnf_pkg::ADDR_BITS)
   ) u_queue (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_addr (head_ff[gnf_pkg::ADDR_BITS-1:0]),
      .rd_data (q_rd_data)
   );

   gnf_nbr u_nbr (
      .clock   (clock),
      .reset   (reset),
      .ctl     (nbr_ctl),
      .cur_row (cur_row_ff),
      .cur_col (cur_col_ff),
      .n_rows  (n_rows),
      .n_cols  (n_cols),
      .nbr     (nbr)
   );

   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      ctr_val_in   = ctr_val_ff;
      first_in     = 1'b0;
      ev_valid_in  = 1'b0;
      ev_addr_in   = nbr.addr;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      rd_inside_in = rd_inside_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;

      g_wr_en      = 1'b0;
      g_wr_addr    = ev_addr_ff;
      g_wr_data    = ctr_val_ff;
      g_rd_addr    = {cur_row_ff, cur_col_ff};
      q_wr_en      = 1'b0;
      q_wr_addr    = tail_ff[gnf_pkg::ADDR_BITS-1:0];
      q_wr_data    = {cur_row_ff, cur_col_ff};
      nbr_ctl      = '{clear: 1'b0, step: 1'b0};

      case (state_ff)
         S_IDLE: begin
            g_rd_addr = {req_row, req_col};
            g_wr_addr = {req_row, req_col};
            g_wr_data = req_cell_value;
            if (accept) begin
               case (req_opcode)
                  gnf_pkg::OP_WRITE: begin
                     g_wr_en = req_inside;
                  end
                  gnf_pkg::OP_READ: begin
                     rd_inside_in = req_inside;
                     state_in     = S_READ;
                  end
                  gnf_pkg::OP_RUN: begin
                     head_in    = '0;
                     tail_in    = '0;
                     fill_in    = '0;
                     cur_row_in = '0;
                     cur_col_in = '0;
                     // With no rows or no columns the queue stays empty.
                     if (n_rows == '0 || n_cols == '0) begin
                        state_in = S_POP;
                     end else begin
                        state_in = S_SEED_CTR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = gnf_pkg::KIND_READ;
            rsp_value_in = rd_inside_ff ? g_rd_data : nodata_ff;
            rsp_count_in = '0;
            state_in     = S_IDLE;
         end

         // The center read goes out here; its data arrives with the first
         // neighbor read of the next state.
         S_SEED_CTR: begin
            nbr_ctl.clear = 1'b1;
            first_in      = 1'b1;
            state_in      = S_SEED_NB;
         end

         S_SEED_NB, S_SEED_DRAIN: begin
            logic done;
            done          = 1'b0;
            g_rd_addr     = nbr.addr;
            nbr_ctl.step  = 1'b1;
            ev_valid_in   = nbr.inb && (state_ff == S_SEED_NB);
            if (first_ff) begin
               // A no-data center is never a seed.
               done = rd_is_nodata;
            end else if (ev_valid_ff && rd_is_nodata) begin
               done    = 1'b1;
               q_wr_en = queue_room;
               if (queue_room) begin
                  tail_in = tail_ff + gnf_pkg::count_type'(1);
               end
            end else if (state_ff == S_SEED_DRAIN) begin
               done = 1'b1;
            end else if (nbr.last) begin
               state_in = S_SEED_DRAIN;
            end
            if (done) begin
               ev_valid_in = 1'b0;
               state_in    = S_SEED_CTR;
               if (col_next < n_cols) begin
                  cur_col_in = col_next[gnf_pkg::COL_BITS-1:0];
               end else begin
                  cur_col_in = '0;
                  if (row_next < n_rows) begin
                     cur_row_in = row_next[gnf_pkg::ROW_BITS-1:0];
                  end else begin
                     state_in = S_POP;
                  end
               end
            end
         end

         S_POP: begin
            if (head_ff < tail_ff) begin
               head_in  = head_ff + gnf_pkg::count_type'(1);
               state_in = S_POP_WAIT;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = gnf_pkg::KIND_FILL;
               rsp_value_in = '0;
               rsp_count_in = fill_ff;
               state_in     = S_IDLE;
            end
         end

         // The popped cell address is on the queue read port now.
         S_POP_WAIT: begin
            g_rd_addr     = q_rd_data;
            cur_row_in    = q_rd_data[gnf_pkg::ADDR_BITS-1:gnf_pkg::COL_BITS];
            cur_col_in    = q_rd_data[gnf_pkg::COL_BITS-1:0];
            nbr_ctl.clear = 1'b1;
            first_in      = 1'b1;
            state_in      = S_BFS_NB;
         end

         S_BFS_NB, S_BFS_DRAIN: begin
            g_rd_addr    = nbr.addr;
            nbr_ctl.step = 1'b1;
            ev_valid_in  = nbr.inb && (state_ff == S_BFS_NB);
            if (first_ff) begin
               ctr_val_in = g_rd_data;
            end else if (ev_valid_ff && rd_is_nodata) begin
               // Fill the neighbor with the center's word and queue it.
               g_wr_en   = 1'b1;
               fill_in   = fill_ff + gnf_pkg::count_type'(1);
               q_wr_en   = queue_room;
               q_wr_data = ev_addr_ff;
               if (queue_room) begin
                  tail_in = tail_ff + gnf_pkg::count_type'(1);
               end
            end
            if (state_ff == S_BFS_DRAIN) begin
               state_in = S_POP;
            end else if (nbr.last) begin
               state_in = S_BFS_DRAIN;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nodata_ff    <= gnf_pkg::NODATA_RESET;
         rows_ff      <= gnf_pkg::ROWS_RESET;
         cols_ff      <= gnf_pkg::COLS_RESET;
         first_ff     <= 1'b0;
         ev_valid_ff  <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         ev_valid_ff  <= ev_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               gnf_pkg::CSR_NODATA: nodata_ff <= csr_write_data;
               gnf_pkg::CSR_ROWS:   rows_ff   <= csr_write_data[gnf_pkg::DIM_BITS-1:0];
               gnf_pkg::CSR_COLS:   cols_ff   <= csr_write_data[gnf_pkg::DIM_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
      cur_row_ff   <= cur_row_in;
      cur_col_ff   <= cur_col_in;
      ctr_val_ff   <= ctr_val_in;
      ev_addr_ff   <= ev_addr_in;
      rd_inside_ff <= rd_inside_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_read_value   = rsp_value_ff;
   assign rsp_cells_filled = rsp_count_ff;

endmodule

// File: rtl/gnf_ram.sv
// ----------------------------------------------------------------------------
// gnf_ram: simple dual-port synchronous RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module gnf_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/gnf_nbr.sv
// ----------------------------------------------------------------------------
// gnf_nbr: 8-connected neighbor walker
// Steps through the 3x3 window around a center cell in row-then-column order
// and gives each neighbor's address and whether it lies inside the grid.
// ----------------------------------------------------------------------------
module gnf_nbr (
   input  logic                 clock,
   input  logic                 reset,
   input  gnf_pkg::nbr_ctl_type ctl,
   input  gnf_pkg::row_type     cur_row,
   input  gnf_pkg::col_type     cur_col,
   input  gnf_pkg::dim_type     n_rows,
   input  gnf_pkg::dim_type     n_cols,
   output gnf_pkg::nbr_type     nbr
);

   gnf_pkg::offset_type dr_ff, dr_in;
   gnf_pkg::offset_type dc_ff, dc_in;
   gnf_pkg::dim_type    r_p1, c_p1, r_idx, c_idx;

   always_comb begin
      dr_in = dr_ff;
      dc_in = dc_ff;
      if (ctl.clear) begin
         dr_in = '0;
         dc_in = '0;
      end else if (ctl.step) begin
         if (dc_ff == gnf_pkg::OFS_LAST) begin
            dc_in = '0;
            dr_in = dr_ff + 2'd1;
         end else begin
            dc_in = dc_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dr_ff <= '0;
         dc_ff <= '0;
      end else begin
         dr_ff <= dr_in;
         dc_ff <= dc_in;
      end
   end

   // Positions are carried plus one so that the row above row zero is zero.
   assign r_p1  = {1'b0, cur_row} + gnf_pkg::dim_type'(dr_ff);
   assign c_p1  = {1'b0, cur_col} + gnf_pkg::dim_type'(dc_ff);
   assign r_idx = r_p1 - gnf_pkg::dim_type'(1);
   assign c_idx = c_p1 - gnf_pkg::dim_type'(1);

   assign nbr.addr = {r_idx[gnf_pkg::ROW_BITS-1:0], c_idx[gnf_pkg::COL_BITS-1:0]};
   assign nbr.inb  = (r_p1 != '0) && (r_p1 <= n_rows) && (c_p1 != '0) && (c_p1 <= n_cols)
                     && !(dr_ff == gnf_pkg::OFS_MID && dc_ff == gnf_pkg::OFS_MID);
   assign nbr.last = (dr_ff == gnf_pkg::OFS_LAST) && (dc_ff == gnf_pkg::OFS_LAST);

endmodule

// File: sim/grid_nearest_fill_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_nearest_fill_checker: result predictor and comparator for the fill block
// Watches the request, result and register channels, keeps its own grid and
// register copies, predicts each read word and each fill count, and compares
// every strobed result field by field with the oldest awaited one.
// ----------------------------------------------------------------------------
module grid_nearest_fill_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic [1:0]                            req_opcode,
   input  gnf_pkg::row_type                      req_row,
   input  gnf_pkg::col_type                      req_col,
   input  logic signed [gnf_pkg::VALUE_BITS-1:0] req_cell_value,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_kind,
   input  logic signed [gnf_pkg::VALUE_BITS-1:0] rsp_read_value,
   input  gnf_pkg::count_type                    rsp_cells_filled,
   input  logic                                  csr_write_enable,
   input  logic [gnf_pkg::CSR_BITS-1:0]          csr_index,
   input  logic [gnf_pkg::VALUE_BITS-1:0]        csr_write_data,
   output int                                    pending,
   output int                                    errors
);
   import gnf_pkg::*;

   typedef struct packed {
      logic      kind;
      value_type read_value;
      count_type cells_filled;
   } result_type;

   value_type  grid_words [CELL_COUNT];
   value_type  nodata_word;
   dim_type    rows_cfg;
   dim_type    cols_cfg;
   result_type awaited_results [$];

   function automatic int span(input dim_type dim, input int limit);
      return (dim > limit) ? limit : int'(dim);
   endfunction

   // Breadth-first fill of the grid in place; returns the number of cells filled.
   function automatic count_type flood_fill();
      int        nr;
      int        nc;
      int        r;
      int        c;
      int        k;
      int        l;
      int        a;
      int        b;
      bit        touches;
      value_type v;
      count_type filled;
      int        frontier [$];
      nr = span(rows_cfg, MAX_ROWS);
      nc = span(cols_cfg, MAX_COLS);
      filled = '0;
      // Seed with every valued cell that borders a no-data cell.
      for (r = 0; r < nr; r++) begin
         for (c = 0; c < nc; c++) begin
            touches = 1'b0;
            for (k = r - 1; k <= r + 1; k++) begin
               for (l = c - 1; l <= c + 1; l++) begin
                  if ((k != r || l != c) && k >= 0 && l >= 0 && k < nr && l < nc &&
                      grid_words[k * MAX_COLS + l] == nodata_word) begin
                     touches = 1'b1;
                  end
               end
            end
            if (grid_words[r * MAX_COLS + c] != nodata_word && touches) begin
               frontier = {frontier, r * MAX_COLS + c};
            end
         end
      end
      while (frontier.size() > 0) begin
         a = frontier.pop_front();
         v = grid_words[a];
         r = a / MAX_COLS;
         c = a % MAX_COLS;
         for (k = r - 1; k <= r + 1; k++) begin
            for (l = c - 1; l <= c + 1; l++) begin
               if ((k != r || l != c) && k >= 0 && l >= 0 && k < nr && l < nc) begin
                  b = k * MAX_COLS + l;
                  if (grid_words[b] == nodata_word) begin
                     grid_words[b] = v;
                     filled++;
                     frontier = {frontier, b};
                  end
               end
            end
         end
      end
      return filled;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      bit         in_region;
      if (reset) begin
         nodata_word = NODATA_RESET;
         rows_cfg    = ROWS_RESET;
         cols_cfg    = COLS_RESET;
         awaited_results.delete();
         pending = 0;
         errors  = 0;
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: result with none awaited, expected none, actual kind %0b %0h %0d",
                        $time, rsp_kind, rsp_read_value, rsp_cells_filled);
               errors++;
            end else begin
               want = awaited_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("read_value", want.read_value, rsp_read_value);
               check_field("cells_filled", 32'(want.cells_filled), 32'(rsp_cells_filled));
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_NODATA: nodata_word = csr_write_data;
               CSR_ROWS:   rows_cfg    = dim_type'(csr_write_data);
               CSR_COLS:   cols_cfg    = dim_type'(csr_write_data);
               default:    ;
            endcase
         end
         if (start && !busy) begin
            in_region = (req_row < span(rows_cfg, MAX_ROWS)) &&
                        (req_col < span(cols_cfg, MAX_COLS));
            case (req_opcode)
               OP_WRITE: if (in_region) grid_words[{req_row, req_col}] = req_cell_value;
               OP_READ: begin
                  want.kind         = KIND_READ;
                  want.read_value   = in_region ? grid_words[{req_row, req_col}] : nodata_word;
                  want.cells_filled = '0;
                  awaited_results   = {awaited_results, want};
               end
               OP_RUN: begin
                  want.kind         = KIND_FILL;
                  want.read_value   = '0;
                  want.cells_filled = flood_fill();
                  awaited_results   = {awaited_results, want};
               end
               default: ;
            endcase
         end
         pending = awaited_results.size();
      end
   end

endmodule

// File: sim/grid_nearest_fill_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_nearest_fill_test: stimulus and verdict for the grid nearest fill block
// Drives a directed opening and then randomized phases of cell writes, reads
// and fill runs under changing grid sizes and no-data words, with bursty
// request timing; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module grid_nearest_fill_test;
   import gnf_pkg::*;

   // Opcode 3 has no meaning and must be ignored by the block.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Slowest correct run: scanning and draining a 144-cell region, plus short
   // sender gaps; the limit leaves wide margin over it.
   localparam int IDLE_LIMIT = 20000;
   localparam int REQUEST_TARGET = 750;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [1:0]                     req_opcode;
   row_type                        req_row;
   col_type                        req_col;
   logic signed [VALUE_BITS-1:0]   req_cell_value;
   logic                           rsp_valid;
   logic                           rsp_kind;
   logic signed [VALUE_BITS-1:0]   rsp_read_value;
   count_type                      rsp_cells_filled;
   logic                           csr_write_enable;
   logic [CSR_BITS-1:0]            csr_index;
   logic [VALUE_BITS-1:0]          csr_write_data;
   int                             pending;
   int                             errors;

   // Stimulus bookkeeping: which cells hold a defined word, the region now in
   // use, the no-data word now set, and the burst pacing of the sender.
   bit        written [CELL_COUNT];
   int        rows_span;
   int        cols_span;
   value_type nodata_now;
   int        sent;
   int        burst_left;
   int        gap_max;
   int        idle_cycles;

   grid_nearest_fill dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_cell_value   (req_cell_value),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_read_value   (rsp_read_value),
      .rsp_cells_filled (rsp_cells_filled),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   grid_nearest_fill_checker fill_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_cell_value   (req_cell_value),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_read_value   (rsp_read_value),
      .rsp_cells_filled (rsp_cells_filled),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pending          (pending),
      .errors           (errors)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The watchdog ends the run when nothing has moved for too long. A fill run
   // accepts nothing while it works, so the limit covers the slowest run.
   initial begin
      idle_cycles = 0;
      wait (reset === 1'b0);
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || csr_write_enable) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   // Cell words lean on a small palette and the extremes so that equal words
   // and no-data collisions come up often; the rest are fully random.
   function automatic value_type pick_word();
      case ($urandom_range(5))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2, 3:    return value_type'($urandom_range(7));
         default: return $urandom;
      endcase
   endfunction

   // Present one request and hold it until the block takes it. The task
   // returns on the falling edge after acceptance, with start still high
   // unless a gap follows, so a burst keeps start up without a glitch.
   task automatic drive(input logic [1:0] op, input int r, input int c,
                        input value_type v);
      int gap;
      start          <= 1'b1;
      req_opcode     <= op;
      req_row        <= row_type'(r);
      req_col        <= col_type'(c);
      req_cell_value <= v;
      do @(posedge clock); while (busy);
      @(negedge clock);
      // Ignored requests (the unused opcode, writes outside the region) do
      // not count toward the stimulus total.
      if (op == OP_WRITE && r < rows_span && c < cols_span) begin
         written[r * MAX_COLS + c] = 1'b1;
         sent++;
      end else if (op != OP_WRITE && op != OP_UNUSED) begin
         sent++;
      end
      // Bursts of random length with random gaps between them; a gap only
      // lowers start when its length is above zero.
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Hold requests off until every awaited result has come and the block is
   // idle, then leave a margin for a write still settling.
   task automatic settle();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
      repeat (4) @(negedge clock);
   endtask

   // Write all three registers back to back. The dimension words sometimes
   // carry random upper bits, which the block must drop.
   task automatic configure(input value_type nd, input int rows_set, input int cols_set);
      logic [31:0] pad;
      pad = ($urandom_range(1) == 0) ? 32'h0 : ($urandom & 32'hFFFF_FF80);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_NODATA;
      csr_write_data   <= nd;
      @(negedge clock);
      csr_index        <= CSR_ROWS;
      csr_write_data   <= pad | 32'(rows_set[6:0]);
      @(negedge clock);
      csr_index        <= CSR_COLS;
      csr_write_data   <= pad | 32'(cols_set[6:0]);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      nodata_now = nd;
      rows_span  = (rows_set[6:0] > MAX_ROWS) ? MAX_ROWS : int'(rows_set[6:0]);
      cols_span  = (cols_set[6:0] > MAX_COLS) ? MAX_COLS : int'(cols_set[6:0]);
   endtask

   initial begin
      int        r;
      int        c;
      int        phase;
      int        p_nodata;
      int        roll;
      int        rows_set;
      int        cols_set;
      value_type nd_pick;
      reset            = 1'b1;
      start            = 1'b0;
      req_opcode       = OP_WRITE;
      req_row          = '0;
      req_col          = '0;
      req_cell_value   = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_NODATA;
      csr_write_data   = '0;
      rows_span        = MAX_ROWS;
      cols_span        = MAX_COLS;
      nodata_now       = NODATA_RESET;
      sent             = 0;
      burst_left       = 0;
      gap_max          = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening on a 3 x 4 grid: the two extreme words sit in
      // opposite corners and everything else is no-data, so one run floods
      // the whole region from two sources.
      configure(NODATA_RESET, 3, 4);
      for (r = 0; r < 3; r++) begin
         for (c = 0; c < 4; c++) begin
            drive(OP_WRITE, r, c, (r == 0 && c == 0) ? 32'h7FFF_FFFF :
                                  (r == 2 && c == 3) ? 32'h8000_0000 : nodata_now);
         end
      end
      drive(OP_READ, 1, 1, '0);
      drive(OP_RUN, 0, 0, '0);
      drive(OP_READ, 1, 1, '0);
      drive(OP_READ, 0, 3, '0);
      // Accesses outside the rows and columns in use: writes are dropped and
      // reads return the no-data word.
      drive(OP_WRITE, 5, 5, 32'h1234_5678);
      drive(OP_READ, 5, 5, '0);
      drive(OP_WRITE, 63, 63, 32'hFFFF_FFFF);
      drive(OP_READ, 63, 63, '0);
      drive(OP_UNUSED, 63, 63, 32'hFFFF_FFFF);
      // A run over a grid with no no-data cells fills nothing; then a single
      // hole is punched and filled again.
      drive(OP_RUN, 0, 0, '0);
      drive(OP_WRITE, 1, 2, nodata_now);
      drive(OP_RUN, 0, 0, '0);
      drive(OP_READ, 1, 2, '0);

      // Random phases. The first ones walk the dimension extremes: empty
      // grids, a full-height or full-width strip and saturating sizes; later
      // ones use small grids. Each phase first gives every cell of the new
      // region a defined word, then mixes writes, reads and runs.
      phase = 0;
      while (sent < REQUEST_TARGET) begin
         settle();
         case ($urandom_range(3))
            0:       nd_pick = value_type'($urandom_range(7));
            1:       nd_pick = ($urandom_range(1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: nd_pick = $urandom;
         endcase
         case (phase)
            0: begin rows_set = 0;   cols_set = 5;   end
            1: begin rows_set = 64;  cols_set = 1;   end
            2: begin rows_set = 127; cols_set = 1;   end
            3: begin rows_set = 1;   cols_set = 64;  end
            4: begin rows_set = 1;   cols_set = 100; end
            5: begin rows_set = 1;   cols_set = 1;   end
            6: begin rows_set = 64;  cols_set = 2;   end
            7: begin rows_set = 5;   cols_set = 0;   end
            default: begin
               rows_set = $urandom_range(1, 12);
               cols_set = $urandom_range(1, 12);
            end
         endcase
         // Every third phase runs with no sender gaps at all.
         gap_max  = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
         p_nodata = $urandom_range(10, 80);
         configure(nd_pick, rows_set, cols_set);

         for (r = 0; r < rows_span; r++) begin
            for (c = 0; c < cols_span; c++) begin
               if (!written[r * MAX_COLS + c]) begin
                  drive(OP_WRITE, r, c,
                        ($urandom_range(99) < p_nodata) ? nodata_now : pick_word());
               end
            end
         end

         repeat ($urandom_range(20, 60)) begin
            // Now and then the sender waits for every result before going on.
            if ($urandom_range(39) == 0) settle();
            if (rows_span > 0 && cols_span > 0 && $urandom_range(9) != 0) begin
               r = $urandom_range(rows_span - 1);
               c = $urandom_range(cols_span - 1);
            end else begin
               r = $urandom_range(MAX_ROWS - 1);
               c = $urandom_range(MAX_COLS - 1);
            end
            roll = $urandom_range(99);
            if (roll < 42) begin
               drive(OP_WRITE, r, c,
                     ($urandom_range(99) < p_nodata) ? nodata_now : pick_word());
            end else if (roll < 78) begin
               drive(OP_READ, r, c, $urandom);
            end else if (roll < 95) begin
               drive(OP_RUN, r, c, $urandom);
            end else begin
               drive(OP_UNUSED, r, c, $urandom);
            end
         end
         phase++;
      end

      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (20) @(negedge clock);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
